// ===== hdl/bvs_pkg.sv =====
// ----------------------------------------------------------------------------
// bvs_pkg
// Shared types and constants for the bounded value set.
// ----------------------------------------------------------------------------
package bvs_pkg;

   localparam int KIND_WIDTH          = 2;
   localparam int VALUE_FIELD_WIDTH   = 32;
   localparam int COUNT_WIDTH         = 8;
   localparam int CAP_WIDTH           = 8;
   localparam int STORE_DEPTH_DEFAULT = 128;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = 8'd100;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_ADD      = 2'd0,
      KIND_REMOVE   = 2'd1,
      KIND_CONTAINS = 2'd2,
      KIND_CLEAR    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // search token walking down the row of cells
   typedef struct packed {
      logic     active;
      kind_type kind;
      logic     allow;   // room left for an add
      logic     found;   // a valid cell matched the key
      logic     placed;  // a free cell has claimed the key
   } tok_type;

   // broadcast to every cell when a transaction finishes, after its token has left the row
   typedef struct packed {
      logic commit;
      logic release_claim;
      logic clear_all;
   } ctrl_type;

endpackage

// ===== hdl/bvs_if.sv =====
// ----------------------------------------------------------------------------
// bvs_req_if / bvs_rsp_if
// Valid/ready channels for requests and responses of the bounded value set.
// ----------------------------------------------------------------------------
interface bvs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [bvs_pkg::KIND_WIDTH-1:0]        kind;
   logic [bvs_pkg::VALUE_FIELD_WIDTH-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bvs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            ok;
   logic [bvs_pkg::COUNT_WIDTH-1:0] count;
   logic                            is_empty;

   modport source (output valid, output ok, output count, output is_empty, input ready);
   modport sink   (input valid, input ok, input count, input is_empty, output ready);
endinterface

// ===== hdl/bvs_cell.sv =====
// ----------------------------------------------------------------------------
// bvs_cell
// One entry of the set: value, valid and claim bits, plus one token stage.
// ----------------------------------------------------------------------------
module bvs_cell #(
   parameter int VALUE_WIDTH = bvs_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bvs_pkg::tok_type       tok_in,
   input  logic [VALUE_WIDTH-1:0] key_in,
   input  bvs_pkg::ctrl_type      ctrl,
   output bvs_pkg::tok_type       tok_out,
   output logic [VALUE_WIDTH-1:0] key_out
);

   logic                   valid_ff, valid_in;
   logic                   claim_ff, claim_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   bvs_pkg::tok_type       tok_ff, tok_in_next;
   logic [VALUE_WIDTH-1:0] key_ff;
   logic                   hit;

   assign hit = valid_ff && (value_ff == key_in);

   always_comb begin
      valid_in    = valid_ff;
      claim_in    = claim_ff;
      value_in    = value_ff;
      tok_in_next = tok_in;

      // broadcasts only arrive while the row holds no token
      if (ctrl.clear_all) begin
         valid_in = 1'b0;
         claim_in = 1'b0;
      end else if (ctrl.commit && claim_ff) begin
         valid_in = 1'b1;
         claim_in = 1'b0;
      end else if (ctrl.release_claim) begin
         claim_in = 1'b0;
      end

      if (tok_in.active) begin
         case (tok_in.kind)
            bvs_pkg::KIND_ADD: begin
               if (hit) begin
                  tok_in_next.found = 1'b1;
               end
               // first free cell takes the key tentatively
               if (!valid_ff && !claim_ff && tok_in.allow && !tok_in.placed) begin
                  claim_in           = 1'b1;
                  value_in           = key_in;
                  tok_in_next.placed = 1'b1;
               end
            end
            bvs_pkg::KIND_REMOVE: begin
               if (hit) begin
                  valid_in          = 1'b0;
                  tok_in_next.found = 1'b1;
               end
            end
            bvs_pkg::KIND_CONTAINS: begin
               if (hit) begin
                  tok_in_next.found = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         claim_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         claim_ff <= claim_in;
         tok_ff   <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      key_ff   <= key_in;
   end

   assign tok_out = tok_ff;
   assign key_out = key_ff;

endmodule

// ===== hdl/bounded_value_set.sv =====
// Search: the search token visits one cell per cycle down the row, and the
//   next request is not taken until the current one has finished.
// A pending response does not block a new request; the finished token waits at the row's end.
// Reset: synchronous, clears all valid bits, the count, and capacity to 100.
// ----------------------------------------------------------------------------
// bounded_value_set
// Set of distinct values held in a row of cells, searched by a walking token.
// ----------------------------------------------------------------------------
module bounded_value_set #(
   parameter int STORE_DEPTH = bvs_pkg::STORE_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = bvs_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   bvs_req_if.sink                         req_ch,
   bvs_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [bvs_pkg::CAP_WIDTH-1:0]   csr_write_data
);

   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > bvs_pkg::CAP_WIDTH) ? CNT_W : bvs_pkg::CAP_WIDTH;

   bvs_pkg::state_type            state_ff, state_in;
   logic [bvs_pkg::CAP_WIDTH-1:0] cap_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   bvs_pkg::tok_type              fin_tok_ff;

   bvs_pkg::tok_type              tok [0:STORE_DEPTH];
   logic [VALUE_WIDTH-1:0]        key [0:STORE_DEPTH];
   logic [STORE_DEPTH-1:0]        act_vec;
   bvs_pkg::ctrl_type             ctrl;

   logic                          accept;
   logic                          finish_go;
   logic                          fin_ok;

   logic                             rsp_valid_ff;
   logic                             rsp_ok_ff;
   logic [bvs_pkg::COUNT_WIDTH-1:0]  rsp_count_ff;
   logic                             rsp_empty_ff;

   assign accept = req_ch.valid && req_ch.ready;

   // head of the row
   always_comb begin
      tok[0].active = accept;
      tok[0].kind   = bvs_pkg::kind_type'(req_ch.kind);
      tok[0].allow  = (CMP_W'(count_ff) < CMP_W'(cap_ff)) &&
                      (CMP_W'(count_ff) < CMP_W'(STORE_DEPTH));
      tok[0].found  = 1'b0;
      tok[0].placed = 1'b0;
   end
   assign key[0] = VALUE_WIDTH'(req_ch.value);

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      bvs_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[i]),
         .key_in  (key[i]),
         .ctrl    (ctrl),
         .tok_out (tok[i+1]),
         .key_out (key[i+1])
      );
      assign act_vec[i] = tok[i+1].active;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bvs_pkg::ST_IDLE: begin
            if (accept) state_in = bvs_pkg::ST_RUN;
         end
         bvs_pkg::ST_RUN: begin
            if (tok[STORE_DEPTH].active) state_in = bvs_pkg::ST_FINISH;
         end
         bvs_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = bvs_pkg::ST_IDLE;
         end
         default: state_in = bvs_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ch.ready = (state_ff == bvs_pkg::ST_IDLE);
      finish_go    = (state_ff == bvs_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);
      case (fin_tok_ff.kind)
         bvs_pkg::KIND_ADD:      fin_ok = fin_tok_ff.placed && !fin_tok_ff.found;
         bvs_pkg::KIND_REMOVE:   fin_ok = fin_tok_ff.found;
         bvs_pkg::KIND_CONTAINS: fin_ok = fin_tok_ff.found;
         default:                fin_ok = 1'b1;
      endcase
      ctrl.commit        = finish_go && (fin_tok_ff.kind == bvs_pkg::KIND_ADD) && fin_ok;
      ctrl.release_claim = finish_go && !ctrl.commit;
      ctrl.clear_all     = finish_go && (fin_tok_ff.kind == bvs_pkg::KIND_CLEAR);
   end

   always_comb begin
      count_in = count_ff;
      if (finish_go) begin
         case (fin_tok_ff.kind)
            bvs_pkg::KIND_ADD: begin
               if (fin_ok) count_in = count_ff + CNT_W'(1);
            end
            bvs_pkg::KIND_REMOVE: begin
               if (fin_ok) count_in = count_ff - CNT_W'(1);
            end
            bvs_pkg::KIND_CLEAR: count_in = '0;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bvs_pkg::ST_IDLE;
         cap_ff       <= bvs_pkg::CAPACITY_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_write_enable) cap_ff <= csr_write_data;
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tok[STORE_DEPTH].active) fin_tok_ff <= tok[STORE_DEPTH];
      if (finish_go) begin
         rsp_ok_ff    <= fin_ok;
         rsp_count_ff <= bvs_pkg::COUNT_WIDTH'(count_in);
         rsp_empty_ff <= (count_in == '0);
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.ok       = rsp_ok_ff;
   assign rsp_ch.count    = rsp_count_ff;
   assign rsp_ch.is_empty = rsp_empty_ff;

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(act_vec))
      else $error("more than one search token in the cell row");

   a_bcast_quiet: assert property (@(posedge clock) disable iff (reset)
      (ctrl.commit || ctrl.clear_all) |-> (act_vec == '0))
      else $error("broadcast while a token is in the cell row");

   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      finish_go |=> rsp_ch.valid)
      else $error("finished transaction produced no response");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(STORE_DEPTH))
      else $error("held count exceeds store depth");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bounded_value_set. A shadow copy of the set predicts
// ok, count and is_empty for every accepted request. Directed corner cases run
// first, then random phases with different capacities and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DEPTH          = bvs_pkg::STORE_DEPTH_DEFAULT;
   localparam int DRAIN_CYCLES   = DEPTH + 4;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      bvs_pkg::kind_type kind;
      logic [31:0]       value;
      bit                drain_first;  // hold until every reply is back
   } set_op_type;

   typedef struct {
      logic                            ok;
      logic [bvs_pkg::COUNT_WIDTH-1:0] count;
      logic                            is_empty;
   } set_reply_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_write_enable;
   logic [bvs_pkg::CAP_WIDTH-1:0] csr_write_data;

   bvs_req_if req_if ();
   bvs_rsp_if rsp_if ();

   bounded_value_set dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   set_op_type    request_queue[$];
   set_reply_type pending_replies[$];
   logic [31:0]   held_values[$];     // shadow contents, order irrelevant
   int unsigned   effective_cap;

   int ops_issued      = 0;
   int ops_accepted    = 0;
   int replies_checked = 0;
   int error_count     = 0;
   int idle_cycles     = 0;
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int peak_count      = 0;
   int kind_tally[4]   = '{0, 0, 0, 0};
   bit req_fired       = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Shadow set: applies one operation and returns the reply it produces.
   function automatic set_reply_type apply_set_op(set_op_type op);
      set_reply_type r;
      int            hit;
      hit = -1;
      foreach (held_values[i])
         if (held_values[i] == op.value) hit = i;
      r.ok = 1'b0;
      case (op.kind)
         bvs_pkg::KIND_ADD: begin
            if (hit < 0 && held_values.size() < effective_cap) begin
               held_values.insert(held_values.size(), op.value);
               r.ok = 1'b1;
            end
         end
         bvs_pkg::KIND_REMOVE: begin
            if (hit >= 0) begin
               held_values.delete(hit);
               r.ok = 1'b1;
            end
         end
         bvs_pkg::KIND_CONTAINS: begin
            r.ok = (hit >= 0);
         end
         default: begin
            held_values.delete();
            r.ok = 1'b1;
         end
      endcase
      r.count    = bvs_pkg::COUNT_WIDTH'(held_values.size());
      r.is_empty = (held_values.size() == 0);
      return r;
   endfunction

   task automatic push_op(bvs_pkg::kind_type k, logic [31:0] v, bit drain = 1'b0);
      set_op_type op;
      op.kind        = k;
      op.value       = v;
      op.drain_first = drain;
      request_queue.insert(request_queue.size(), op);
      ops_issued++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (ops_accepted != ops_issued || pending_replies.size() != 0);
   endtask

   task automatic write_capacity(logic [bvs_pkg::CAP_WIDTH-1:0] cap);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      effective_cap = (cap > DEPTH) ? DEPTH : cap;
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
   endtask

   // Mostly values from a small pool (half of it taken from the current
   // contents) so that hits, duplicates and removes actually land.
   task automatic run_random(int n, int pool_size, int drain_every);
      logic [31:0]       pool[$];
      int                r;
      bvs_pkg::kind_type k;
      logic [31:0]       v;
      for (int i = 0; i < pool_size; i++) begin
         if (held_values.size() != 0 && $urandom_range(1) == 1)
            pool.insert(pool.size(), held_values[$urandom_range(held_values.size() - 1)]);
         else
            pool.insert(pool.size(), $urandom());
      end
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 38)      k = bvs_pkg::KIND_ADD;
         else if (r < 68) k = bvs_pkg::KIND_REMOVE;
         else if (r < 94) k = bvs_pkg::KIND_CONTAINS;
         else             k = bvs_pkg::KIND_CLEAR;
         v = ($urandom_range(9) == 0) ? $urandom() : pool[$urandom_range(pool_size - 1)];
         push_op(k, v, drain_every != 0 && (i % drain_every) == drain_every - 1);
      end
   endtask

   // Driver: presents the next queued transaction at the falling edge.
   always @(negedge clock) begin : drive_proc
      set_op_type op;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.kind  <= bvs_pkg::KIND_ADD;
         req_if.value <= '0;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         if (req_if.valid && !req_fired) begin
            // hold the current transaction until it is taken
         end else if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                      (!request_queue[0].drain_first || pending_replies.size() == 0)) begin
            op = request_queue.pop_front();
            req_if.valid <= 1'b1;
            req_if.kind  <= op.kind;
            req_if.value <= op.value;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: predicts on accepted requests, checks accepted responses.
   always @(posedge clock) begin : monitor_proc
      set_op_type    op;
      set_reply_type exp;
      req_fired <= !reset && req_if.valid === 1'b1 && req_if.ready === 1'b1;
      if (!reset) begin
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            op.kind        = bvs_pkg::kind_type'(req_if.kind);
            op.value       = req_if.value;
            op.drain_first = 1'b0;
            pending_replies.insert(pending_replies.size(), apply_set_op(op));
            kind_tally[op.kind]++;
            ops_accepted++;
            if (held_values.size() > peak_count) peak_count = held_values.size();
         end
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            replies_checked++;
            if (pending_replies.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               exp = pending_replies.pop_front();
               if (rsp_if.ok !== exp.ok) begin
                  $error("ok: expected %0d, got %0d", exp.ok, rsp_if.ok);
                  error_count++;
               end
               if (rsp_if.count !== exp.count) begin
                  $error("count: expected %0d, got %0d", exp.count, rsp_if.count);
                  error_count++;
               end
               if (rsp_if.is_empty !== exp.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", exp.is_empty, rsp_if.is_empty);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any transaction on either channel.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      logic [bvs_pkg::CAP_WIDTH-1:0] last_cap;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      effective_cap    = bvs_pkg::CAPACITY_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset capacity, field extremes, duplicates, absent values
      set_idling(0, 0);
      push_op(bvs_pkg::KIND_CONTAINS, 32'h0000_0000);
      push_op(bvs_pkg::KIND_REMOVE,   32'hFFFF_FFFF);
      push_op(bvs_pkg::KIND_ADD,      32'h0000_0000);
      push_op(bvs_pkg::KIND_ADD,      32'hFFFF_FFFF);
      push_op(bvs_pkg::KIND_ADD,      32'h0000_0000);
      push_op(bvs_pkg::KIND_CONTAINS, 32'h0000_0000);
      push_op(bvs_pkg::KIND_CONTAINS, 32'hFFFF_FFFF);
      push_op(bvs_pkg::KIND_CONTAINS, 32'h8000_0000);
      push_op(bvs_pkg::KIND_REMOVE,   32'h0000_0000);
      push_op(bvs_pkg::KIND_REMOVE,   32'h0000_0000);
      push_op(bvs_pkg::KIND_CONTAINS, 32'h0000_0000);
      push_op(bvs_pkg::KIND_ADD,      32'hAAAA_AAAA);
      push_op(bvs_pkg::KIND_ADD,      32'h5555_5555);
      push_op(bvs_pkg::KIND_ADD,      32'h0000_0001);
      push_op(bvs_pkg::KIND_CLEAR,    32'h1234_5678);
      push_op(bvs_pkg::KIND_CONTAINS, 32'hAAAA_AAAA);
      push_op(bvs_pkg::KIND_CLEAR,    32'hFFFF_FFFF);
      push_op(bvs_pkg::KIND_ADD,      32'h8000_0000);
      // zero capacity with a value still held
      write_capacity(8'd0);
      push_op(bvs_pkg::KIND_ADD,      32'h0000_0007);
      push_op(bvs_pkg::KIND_CONTAINS, 32'h8000_0000);
      push_op(bvs_pkg::KIND_ADD,      32'h8000_0000);
      push_op(bvs_pkg::KIND_REMOVE,   32'h8000_0000);
      write_capacity(8'd1);
      push_op(bvs_pkg::KIND_ADD,      32'h0000_0009);
      push_op(bvs_pkg::KIND_ADD,      32'h0000_000A);

      // capacity above depth: fill the whole store, then push past it
      write_capacity(8'd255);
      for (int i = 0; i < DEPTH + 4; i++) push_op(bvs_pkg::KIND_ADD, $urandom());
      run_random(8, 8, 0);

      // capacity lowered far below the count
      write_capacity(8'd3);
      set_idling(51, 0);
      run_random(60, 24, 0);

      write_capacity(8'd0);
      set_idling(0, 51);
      run_random(40, 12, 0);

      write_capacity(8'd128);
      set_idling(23, 23);
      run_random(80, 20, 0);

      // random capacity, sender drains the pipe now and then
      last_cap = bvs_pkg::CAP_WIDTH'($urandom_range(4, 127));
      write_capacity(last_cap);
      run_random(80, 16, 16);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d transactions (add %0d, remove %0d, contains %0d, clear %0d),",
               ops_accepted, kind_tally[bvs_pkg::KIND_ADD], kind_tally[bvs_pkg::KIND_REMOVE],
               kind_tally[bvs_pkg::KIND_CONTAINS], kind_tally[bvs_pkg::KIND_CLEAR]);
      $display("%0d replies; capacities: reset, 0, 1, 3, 128, 255, %0d; peak count %0d.",
               replies_checked, last_cap, peak_count);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
